// ===== design/tgasd_pkg.sv =====
// Shared types and constants for the TGA stream decoder.
`default_nettype none

package tgasd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_IDSKIP = 3'd1,
    PH_PACKET = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Supported pixel depths
  typedef enum logic [1:0] {
    DEPTH_NONE = 2'd0,
    DEPTH_16   = 2'd1,
    DEPTH_24   = 2'd2,
    DEPTH_32   = 2'd3
  } depth_e;

  // Header byte offsets
  localparam logic [8:0] HDR_ID_LEN   = 9'd0;
  localparam logic [8:0] HDR_TYPE     = 9'd2;
  localparam logic [8:0] HDR_WIDTH_LO = 9'd12;
  localparam logic [8:0] HDR_WIDTH_HI = 9'd13;
  localparam logic [8:0] HDR_HEIGHT_LO = 9'd14;
  localparam logic [8:0] HDR_HEIGHT_HI = 9'd15;
  localparam logic [8:0] HDR_DEPTH    = 9'd16;
  localparam logic [8:0] HDR_LAST     = 9'd17;

  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] BPP_16       = 8'd16;
  localparam logic [7:0] BPP_24       = 8'd24;
  localparam logic [7:0] BPP_32       = 8'd32;
  localparam logic [7:0] REPEAT_BIAS  = 8'd127;

  localparam logic [2:0] CH_NONE      = 3'd0;
  localparam logic [2:0] CH_RGB       = 3'd3;
  localparam logic [2:0] CH_RGBA      = 3'd4;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One result word before color formatting
  typedef struct packed {
    kind_e       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    depth_e      depth;
    logic [31:0] pix;
    logic [7:0]  run;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== design/tgasd_front.sv =====
// Byte parser: header, ID skip, RLE packets and pixel assembly.
`default_nettype none

module tgasd_front import tgasd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] file_byte_i,
  input  wire logic       start_of_file_i,
  output logic            push_o,
  output res_t            res_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [8:0]  cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic [7:0]  idlen_q, idlen_d, cur_idlen;
  logic        comp_q, comp_d, cur_comp;
  logic [15:0] width_q, width_d, cur_width;
  logic [15:0] height_q, height_d, cur_height;
  depth_e      depth_q, depth_d, cur_depth;
  logic [31:0] pixrem_q, pixrem_d, cur_pixrem;
  logic [7:0]  pktrem_q, pktrem_d, cur_pktrem;
  logic        pktrep_q, pktrep_d, cur_pktrep;
  logic [31:0] pb_q, pb_d, cur_pb;
  logic [1:0]  idx_q, idx_d, cur_idx;
  logic [31:0] prod_q;

  // decode
  logic        hdr_end, finish, fin_ok, empty;
  logic        pix_last, pix_ok;
  logic [1:0]  last_idx;
  logic [31:0] pix_new;
  logic [7:0]  run;
  logic [31:0] pixrem_new;
  logic [7:0]  pktrem_new;
  phase_e      fin_phase;

  // Start of file clears state before the byte is parsed
  always_comb begin
    if (start_of_file_i) begin
      cur_phase  = PH_HEADER;
      cur_cnt    = '0;
      cur_idlen  = '0;
      cur_comp   = 1'b0;
      cur_width  = '0;
      cur_height = '0;
      cur_depth  = DEPTH_NONE;
      cur_pixrem = '0;
      cur_pktrem = '0;
      cur_pktrep = 1'b0;
      cur_pb     = '0;
      cur_idx    = '0;
    end else begin
      cur_phase  = phase_q;
      cur_cnt    = cnt_q;
      cur_idlen  = idlen_q;
      cur_comp   = comp_q;
      cur_width  = width_q;
      cur_height = height_q;
      cur_depth  = depth_q;
      cur_pixrem = pixrem_q;
      cur_pktrem = pktrem_q;
      cur_pktrep = pktrep_q;
      cur_pb     = pb_q;
      cur_idx    = idx_q;
    end
  end

  always_comb begin
    cnt_inc = cur_cnt + 9'd1;
    hdr_end = (cur_cnt >= HDR_LAST);
    finish  = ((cur_phase == PH_HEADER) && hdr_end && (cur_idlen == 8'd0)) ||
              ((cur_phase == PH_IDSKIP) && (cnt_inc >= {1'b0, cur_idlen}));
    fin_ok  = (cur_depth != DEPTH_NONE) && !(cur_comp && (cur_depth == DEPTH_16));
    empty   = (cur_width == 16'd0) || (cur_height == 16'd0);
    if (!fin_ok || empty) begin
      fin_phase = PH_DONE;
    end else if (cur_comp) begin
      fin_phase = PH_PACKET;
    end else begin
      fin_phase = PH_PIXEL;
    end

    case (cur_depth)
      DEPTH_16: last_idx = 2'd1;
      DEPTH_24: last_idx = 2'd2;
      default:  last_idx = 2'd3;
    endcase
    pix_ok   = (cur_depth != DEPTH_NONE);
    pix_last = (cur_idx == last_idx);
    pix_new  = cur_pb | ({24'd0, file_byte_i} << {cur_idx, 3'b000});

    if (cur_comp && cur_pktrep) begin
      run = (cur_pixrem < {24'd0, cur_pktrem}) ? cur_pixrem[7:0] : cur_pktrem;
    end else begin
      run = 8'd1;
    end
    pixrem_new = cur_pixrem - {24'd0, run};
    if (!cur_comp) begin
      pktrem_new = cur_pktrem;
    end else if (cur_pktrep) begin
      pktrem_new = 8'd0;
    end else if (cur_pktrem != 8'd0) begin
      pktrem_new = cur_pktrem - 8'd1;
    end else begin
      pktrem_new = 8'd0;
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      phase_d = cur_phase;
      case (cur_phase)
        PH_HEADER: begin
          if (hdr_end) phase_d = (cur_idlen == 8'd0) ? fin_phase : PH_IDSKIP;
        end
        PH_IDSKIP: begin
          if (finish) phase_d = fin_phase;
        end
        PH_PACKET: phase_d = PH_PIXEL;
        PH_PIXEL: begin
          if (!pix_ok) begin
            phase_d = PH_DONE;
          end else if (pix_last) begin
            if (pixrem_new == 32'd0) begin
              phase_d = PH_DONE;
            end else if (cur_comp && (pktrem_new == 8'd0)) begin
              phase_d = PH_PACKET;
            end
          end
        end
        default: phase_d = PH_DONE;
      endcase
    end
  end

  // Datapath and result word
  always_comb begin
    cnt_d    = cnt_q;
    idlen_d  = idlen_q;
    comp_d   = comp_q;
    width_d  = width_q;
    height_d = height_q;
    depth_d  = depth_q;
    pixrem_d = pixrem_q;
    pktrem_d = pktrem_q;
    pktrep_d = pktrep_q;
    pb_d     = pb_q;
    idx_d    = idx_q;
    push_o   = 1'b0;

    res_o.kind     = KIND_HEADER;
    res_o.width    = cur_width;
    res_o.height   = cur_height;
    res_o.channels = (cur_depth == DEPTH_32) ? CH_RGBA : CH_RGB;
    res_o.depth    = cur_depth;
    res_o.pix      = '0;
    res_o.run      = '0;
    res_o.last     = 1'b0;

    if (accept_i) begin
      cnt_d    = cur_cnt;
      idlen_d  = cur_idlen;
      comp_d   = cur_comp;
      width_d  = cur_width;
      height_d = cur_height;
      depth_d  = cur_depth;
      pixrem_d = cur_pixrem;
      pktrem_d = cur_pktrem;
      pktrep_d = cur_pktrep;
      pb_d     = cur_pb;
      idx_d    = cur_idx;

      case (cur_phase)
        PH_HEADER: begin
          case (cur_cnt)
            HDR_ID_LEN:    idlen_d = file_byte_i;
            HDR_TYPE:      comp_d = (file_byte_i == TYPE_RLE);
            HDR_WIDTH_LO:  width_d = {cur_width[15:8], file_byte_i};
            HDR_WIDTH_HI:  width_d = {file_byte_i, cur_width[7:0]};
            HDR_HEIGHT_LO: height_d = {cur_height[15:8], file_byte_i};
            HDR_HEIGHT_HI: height_d = {file_byte_i, cur_height[7:0]};
            HDR_DEPTH: begin
              case (file_byte_i)
                BPP_16:  depth_d = DEPTH_16;
                BPP_24:  depth_d = DEPTH_24;
                BPP_32:  depth_d = DEPTH_32;
                default: depth_d = DEPTH_NONE;
              endcase
            end
            default: ;
          endcase
          cnt_d = hdr_end ? 9'd0 : cnt_inc;
        end
        PH_IDSKIP: cnt_d = cnt_inc;
        PH_PACKET: begin
          if (!file_byte_i[7]) begin
            pktrep_d = 1'b0;
            pktrem_d = file_byte_i + 8'd1;
          end else begin
            pktrep_d = 1'b1;
            pktrem_d = file_byte_i - REPEAT_BIAS;
          end
          pb_d  = '0;
          idx_d = '0;
        end
        PH_PIXEL: begin
          if (pix_ok) begin
            if (pix_last) begin
              pb_d      = '0;
              idx_d     = '0;
              pktrem_d  = pktrem_new;
              pixrem_d  = pixrem_new;
              push_o    = 1'b1;
              res_o.kind = KIND_PIXEL;
              res_o.pix  = pix_new;
              res_o.run  = run;
              res_o.last = (pixrem_new == 32'd0);
            end else begin
              pb_d  = pix_new;
              idx_d = cur_idx + 2'd1;
            end
          end
        end
        default: ;
      endcase

      if (finish) begin
        push_o = 1'b1;
        if (!fin_ok) begin
          res_o.kind     = KIND_ERROR;
          res_o.channels = CH_NONE;
          res_o.last     = 1'b1;
        end else begin
          pixrem_d   = prod_q;
          pb_d       = '0;
          idx_d      = '0;
          pktrem_d   = '0;
          pktrep_d   = 1'b0;
          res_o.last = empty;
        end
      end
    end
  end

  // width*height, ready well before the header closes at byte 17
  always_ff @(posedge clk_i) begin
    prod_q <= {16'd0, width_q} * {16'd0, height_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= '0;
      idlen_q  <= '0;
      comp_q   <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= DEPTH_NONE;
      pixrem_q <= '0;
      pktrem_q <= '0;
      pktrep_q <= 1'b0;
      pb_q     <= '0;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      idlen_q  <= idlen_d;
      comp_q   <= comp_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      pixrem_q <= pixrem_d;
      pktrem_q <= pktrem_d;
      pktrep_q <= pktrep_d;
      pb_q     <= pb_d;
      idx_q    <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgasd_queue.sv =====
// Small result queue between parser and output stage.
`default_nettype none

module tgasd_queue import tgasd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      push_data_i,
  input  wire logic pop_i,
  output res_t      head_o,
  output logic      nonempty_o,
  output logic      full_o
);

  res_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  assign head_o     = slot_q[rptr_q];
  assign nonempty_o = (cnt_q != '0);
  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    if (pop_i)  rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgasd_back.sv =====
// Output stage: color formatting and output register.
`default_nettype none

module tgasd_back import tgasd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  res_t       head_i,
  input  wire logic  nonempty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [1:0] kind_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0] channels_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic [7:0] run_length_o,
  output logic       last_of_image_o
);

  logic       valid_q, valid_d;
  logic [7:0] r_d, g_d, b_d, a_d;

  assign pop_o   = nonempty_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);
  assign out_valid_o = valid_q;

  // 5-5-5 expands by a shift of three; otherwise B,G,R,A byte order
  always_comb begin
    r_d = '0;
    g_d = '0;
    b_d = '0;
    a_d = '0;
    if (head_i.kind == KIND_PIXEL) begin
      if (head_i.depth == DEPTH_16) begin
        b_d = {head_i.pix[4:0],   3'b000};
        g_d = {head_i.pix[9:5],   3'b000};
        r_d = {head_i.pix[14:10], 3'b000};
      end else begin
        b_d = head_i.pix[7:0];
        g_d = head_i.pix[15:8];
        r_d = head_i.pix[23:16];
        if (head_i.depth == DEPTH_32) a_d = head_i.pix[31:24];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_o          <= head_i.kind;
      image_width_o   <= head_i.width;
      image_height_o  <= head_i.height;
      channels_o      <= head_i.channels;
      red_o           <= r_d;
      green_o         <= g_d;
      blue_o          <= b_d;
      alpha_o         <= a_d;
      run_length_o    <= head_i.run;
      last_of_image_o <= head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tga_image_stream_decoder.sv =====
// Top level of the TGA image stream decoder.
//
//  channel  dir  handshake                fields
//  -------  ---  -----------------------  ---------------------------------------
//  in       in   in_valid_i / in_stall_o  file_byte_i, start_of_file_i
//  out      out  out_valid_o / out_stall_i kind_o, image_width_o, image_height_o,
//                                         channels_o, red_o, green_o, blue_o,
//                                         alpha_o, run_length_o, last_of_image_o
//
// One file byte per cycle while in_stall_o is low. A byte that makes a word
// (header, error or pixel run) is written into the two-entry queue and then
// loaded into the output register before it shows at the outputs.
// in_stall_o rises only when that queue is full, i.e. the output side has
// been stalled. width*height is a registered product, refreshed every cycle.
// Reset (rst_ni low, async) or start_of_file_i puts the parser in its header phase.
`default_nettype none

module tga_image_stream_decoder import tgasd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        start_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o,
  output logic [2:0]       channels_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic [7:0]       run_length_o,
  output logic             last_of_image_o
);

  logic accept;
  logic q_push, q_pop, q_nonempty, q_full;
  res_t q_in, q_head;

  // stall only on a full queue
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  tgasd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .file_byte_i     (file_byte_i),
    .start_of_file_i (start_of_file_i),
    .push_o          (q_push),
    .res_o           (q_in)
  );

  tgasd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .nonempty_o  (q_nonempty),
    .full_o      (q_full)
  );

  tgasd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .nonempty_i      (q_nonempty),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .image_width_o   (image_width_o),
    .image_height_o  (image_height_o),
    .channels_o      (channels_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .run_length_o    (run_length_o),
    .last_of_image_o (last_of_image_o)
  );

  // the parser never writes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("result queue overflow");

  // a pixel word always covers at least one pixel
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_PIXEL)) |-> (run_length_o != 8'd0))
    else $error("pixel run of zero length");

  // an error word ends the image and carries no channel count
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_ERROR)) |-> (last_of_image_o && (channels_o == CH_NONE)))
    else $error("error word malformed");

  // a word held under stall keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(run_length_o) && $stable(kind_o)))
    else $error("stalled output word changed");

endmodule

`default_nettype wire

// ===== bench/tb_tga_image_stream_decoder.sv =====
// Testbench for the TGA image stream decoder: byte-level predictor, scoreboard, random files.
`timescale 1ns / 1ps

module tb_tga_image_stream_decoder;
  import tgasd_pkg::*;

  // Sender gives up after this many cycles with no word moving on either side.
  localparam int WATCHDOG_LIMIT = 4000;
  // Receiver's long hold-off, long enough to fill the internal queue and stall input.
  localparam int LONG_HOLD_CYCLES = 300;
  // Idle margin after the last predicted word has been seen.
  localparam int DRAIN_TAIL = 10;
  // Random part stops once this many bytes were actually parsed.
  localparam int RANDOM_BYTES = 1200;

  // One result word as seen on the output port.
  typedef struct {
    kind_e       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run;
    logic        last;
  } tga_word_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Byte-level decoder model plus the queue of words it predicts.
  class tga_scoreboard;
    phase_e      phase;
    logic [8:0]  byte_cnt;
    logic [7:0]  id_len;
    bit          rle;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  bpp;        // 16, 24, 32, or 0 when unsupported
    logic [31:0] pix_left;
    logic [7:0]  pkt_left;
    bit          pkt_repeat;
    logic [31:0] pix_acc;
    logic [1:0]  pix_idx;
    tga_word_t   expected_words[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_HEADER;
      byte_cnt = '0;
      id_len = '0;
      rle = 1'b0;
      width = '0;
      height = '0;
      bpp = '0;
      pix_left = '0;
      pkt_left = '0;
      pkt_repeat = 1'b0;
      pix_acc = '0;
      pix_idx = '0;
    endfunction

    function logic [2:0] out_channels();
      return (bpp == BPP_32) ? CH_RGBA : CH_RGB;
    endfunction

    function void push_word(kind_e k, logic [2:0] ch, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [7:0] a, logic [7:0] run, logic last);
      tga_word_t w;
      w.kind = k;
      w.width = width;
      w.height = height;
      w.channels = ch;
      w.red = r;
      w.green = g;
      w.blue = b;
      w.alpha = a;
      w.run = run;
      w.last = last;
      expected_words.push_back(w);
    endfunction

    // Header fully read: error word, empty-image word, or the start of pixel data.
    function void finish_header();
      if (bpp == 8'd0 || (rle && bpp == BPP_16)) begin
        phase = PH_DONE;
        push_word(KIND_ERROR, CH_NONE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        return;
      end
      pix_left = 32'(width) * 32'(height);
      pix_acc = '0;
      pix_idx = '0;
      pkt_left = '0;
      pkt_repeat = 1'b0;
      if (pix_left == 0) begin
        phase = PH_DONE;
        push_word(KIND_HEADER, out_channels(), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        return;
      end
      phase = rle ? PH_PACKET : PH_PIXEL;
      push_word(KIND_HEADER, out_channels(), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    endfunction

    function void emit_pixel();
      logic [7:0]  r, g, b, a;
      logic [31:0] run;
      logic        last;
      a = 8'd0;
      run = 32'd1;
      last = 1'b0;
      if (bpp == BPP_16) begin
        // 5-5-5 little-endian, top bit dropped
        b = {pix_acc[4:0], 3'b000};
        g = {pix_acc[9:5], 3'b000};
        r = {pix_acc[14:10], 3'b000};
      end else begin
        b = pix_acc[7:0];
        g = pix_acc[15:8];
        r = pix_acc[23:16];
        if (bpp == BPP_32) a = pix_acc[31:24];
      end
      pix_acc = '0;
      pix_idx = '0;
      if (rle) begin
        if (pkt_repeat) begin
          // repeat run clipped to what the image still needs
          run = (32'(pkt_left) < pix_left) ? 32'(pkt_left) : pix_left;
          pkt_left = '0;
        end else if (pkt_left != 0) begin
          pkt_left--;
        end
      end
      pix_left -= run;
      if (pix_left == 0) begin
        phase = PH_DONE;
        last = 1'b1;
      end else if (rle && pkt_left == 0) begin
        phase = PH_PACKET;
      end
      push_word(KIND_PIXEL, out_channels(), r, g, b, a, run[7:0], last);
    endfunction

    // Feeds one accepted byte; returns 1 when the byte was parsed, 0 when ignored.
    function bit decode_byte(logic [7:0] fb, bit sof);
      int  nbytes;
      bit  parsed;
      if (sof) restart();
      parsed = (phase != PH_DONE);
      case (phase)
        PH_HEADER: begin
          case (byte_cnt)
            HDR_ID_LEN:    id_len = fb;
            HDR_TYPE:      rle = (fb == TYPE_RLE);
            HDR_WIDTH_LO:  width[7:0] = fb;
            HDR_WIDTH_HI:  width[15:8] = fb;
            HDR_HEIGHT_LO: height[7:0] = fb;
            HDR_HEIGHT_HI: height[15:8] = fb;
            HDR_DEPTH:     bpp = (fb == BPP_16 || fb == BPP_24 || fb == BPP_32) ? fb : 8'd0;
            default: ;
          endcase
          if (byte_cnt >= HDR_LAST) begin
            byte_cnt = '0;
            if (id_len == 0) finish_header();
            else phase = PH_IDSKIP;
          end else begin
            byte_cnt++;
          end
        end
        PH_IDSKIP: begin
          byte_cnt = byte_cnt + 9'd1;
          if (byte_cnt >= {1'b0, id_len}) finish_header();
        end
        PH_PACKET: begin
          if (fb <= REPEAT_BIAS) begin
            pkt_repeat = 1'b0;
            pkt_left = fb + 8'd1;
          end else begin
            pkt_repeat = 1'b1;
            pkt_left = fb - REPEAT_BIAS;
          end
          pix_acc = '0;
          pix_idx = '0;
          phase = PH_PIXEL;
        end
        PH_PIXEL: begin
          nbytes = int'(bpp) / 8;
          if (nbytes < 2 || nbytes > 4) begin
            phase = PH_DONE;
          end else begin
            pix_acc |= 32'(fb) << (8 * pix_idx);
            if (int'(pix_idx) + 1 >= nbytes) emit_pixel();
            else pix_idx++;
          end
        end
        default: ;
      endcase
      return parsed;
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_word(tga_word_t got);
      tga_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("word with nothing expected: kind %0d", got.kind);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      compare_field("kind", exp_w.kind, got.kind);
      compare_field("image_width", exp_w.width, got.width);
      compare_field("image_height", exp_w.height, got.height);
      compare_field("channels", exp_w.channels, got.channels);
      compare_field("red", exp_w.red, got.red);
      compare_field("green", exp_w.green, got.green);
      compare_field("blue", exp_w.blue, got.blue);
      compare_field("alpha", exp_w.alpha, got.alpha);
      compare_field("run_length", exp_w.run, got.run);
      compare_field("last_of_image", exp_w.last, got.last);
    endfunction
  endclass

  // DUT connections; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  file_byte = 8'd0;
  logic        start_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channels;
  logic [7:0]  red, green, blue, alpha;
  logic [7:0]  run_length;
  logic        last_of_image;

  tga_scoreboard sb = new();
  logic [7:0]    file_bytes[$];   // file under construction
  int            burst_left = 0;
  int            parsed_count = 0;
  int            idle_cycles = 0;
  bit            long_hold_req = 1'b0;
  int            long_hold_left = 0;
  stall_mode_e   stall_mode = STALL_NONE;
  int            mode_left = 0;
  int            cycle_cnt = 0;
  tga_word_t     seen_word;

  always #2 clk = ~clk;

  tga_image_stream_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .file_byte_i     (file_byte),
    .start_of_file_i (start_of_file),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .image_width_o   (image_width),
    .image_height_o  (image_height),
    .channels_o      (channels),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .alpha_o         (alpha),
    .run_length_o    (run_length),
    .last_of_image_o (last_of_image)
  );

  // ---------------------------------------------------------------------------
  // File builders. Everything lands in file_bytes and goes out via send_file.
  // ---------------------------------------------------------------------------

  // Random byte biased toward all-zeros and all-ones.
  function automatic logic [7:0] rand_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // 18-byte header followed by the ID field; unused header bytes get random filler.
  function automatic void put_header(int id_len, logic [7:0] img_type, int w, int h,
                                     logic [7:0] depth);
    int i;
    file_bytes.push_back(8'(id_len));
    file_bytes.push_back(rand_byte());
    file_bytes.push_back(img_type);
    for (i = 3; i < 12; i++) file_bytes.push_back(rand_byte());
    file_bytes.push_back(8'(w));
    file_bytes.push_back(8'(w >> 8));
    file_bytes.push_back(8'(h));
    file_bytes.push_back(8'(h >> 8));
    file_bytes.push_back(depth);
    file_bytes.push_back(rand_byte());
    for (i = 0; i < id_len; i++) file_bytes.push_back(rand_byte());
  endfunction

  function automatic void put_raw_pixels(int count, int nbytes);
    int i;
    for (i = 0; i < count * nbytes; i++) file_bytes.push_back(rand_byte());
  endfunction

  // RLE packets covering count pixels; with overrun the last packet may run past the end.
  function automatic void put_rle_pixels(int count, int nbytes, bit overrun);
    int left, n, cap;
    left = count;
    while (left > 0) begin
      cap = overrun ? left + 3 : left;
      if (cap > 128) cap = 128;
      n = $urandom_range(1, cap);
      if ($urandom_range(0, 1)) begin
        file_bytes.push_back(8'(n + 127));
        put_raw_pixels(1, nbytes);
      end else begin
        file_bytes.push_back(8'(n - 1));
        put_raw_pixels(n, nbytes);
      end
      left -= n;
    end
  endfunction

  // Builds one random file; returns whether its first byte carries start_of_file.
  function automatic bit build_random_file();
    int         pick, w, h, id_len, nbytes, cut;
    logic [7:0] bpp, img_type;
    bit         rle;
    pick = $urandom_range(0, 99);
    id_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    case ($urandom_range(0, 2))
      0: bpp = BPP_16;
      1: bpp = BPP_24;
      default: bpp = BPP_32;
    endcase
    rle = (bpp != BPP_16) && $urandom_range(0, 1);
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
    end
    nbytes = int'(bpp) / 8;
    do img_type = rand_byte(); while (img_type == TYPE_RLE);
    if (pick < 80) begin
      // well-formed file, the last eighth of these cut short
      put_header(id_len, rle ? TYPE_RLE : img_type, w, h, bpp);
      if (rle) put_rle_pixels(w * h, nbytes, $urandom_range(0, 4) == 0);
      else put_raw_pixels(w * h, nbytes);
      if (pick >= 70) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        repeat (cut) void'(file_bytes.pop_back());
      end
      return 1'b1;
    end
    if (pick < 90) begin
      // unsupported format, then some bytes that should be ignored
      if ($urandom_range(0, 1)) begin
        put_header(id_len, TYPE_RLE, w, h, BPP_16);
      end else begin
        do bpp = rand_byte(); while (bpp == BPP_16 || bpp == BPP_24 || bpp == BPP_32);
        put_header(id_len, $urandom_range(0, 1) ? TYPE_RLE : img_type, w, h, bpp);
      end
      put_raw_pixels(2, 3);
      return 1'b1;
    end
    if (pick < 95) begin
      // stray bytes with no start mark
      repeat ($urandom_range(1, 6)) file_bytes.push_back(rand_byte());
      return 1'b0;
    end
    // header made of noise, any size or type, plus a random tail
    repeat (18 + $urandom_range(0, 30)) file_bytes.push_back(rand_byte());
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one byte, holding it until accepted. Bursts of random length with gaps.
  task automatic send_byte(input logic [7:0] b, input bit sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    file_byte <= b;
    start_of_file <= sof;
    do @(posedge clk); while (in_stall);
    parsed_count += sb.decode_byte(b, sof);
  endtask

  task automatic send_file(input bit with_sof);
    int i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], with_sof && i == 0);
    file_bytes.delete();
  endtask

  // Sender goes quiet until every predicted word has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: checks words and drives the stall pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt++;
    if (out_valid && !out_stall) begin
      seen_word.kind = kind_e'(kind);
      seen_word.width = image_width;
      seen_word.height = image_height;
      seen_word.channels = channels;
      seen_word.red = red;
      seen_word.green = green;
      seen_word.blue = blue;
      seen_word.alpha = alpha;
      seen_word.run = run_length;
      seen_word.last = last_of_image;
      sb.check_word(seen_word);
    end
    if (long_hold_req) begin
      long_hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (long_hold_left > 0) begin
      // long hold-off: the parser queue fills and in_stall must rise
      long_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= (cycle_cnt % 5 < 2);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: cycles with nothing accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No start mark after reset: parser must still take this as a header. 1x1, 24 bpp.
    put_header(0, 8'd2, 1, 1, BPP_24);
    file_bytes.push_back(8'h10);
    file_bytes.push_back(8'h20);
    file_bytes.push_back(8'h30);
    send_file(1'b0);

    // Largest dimensions and longest ID field, 32 bpp; cut off by the next start mark.
    put_header(255, 8'd2, 65535, 65535, BPP_32);
    repeat (4) file_bytes.push_back(8'hFF);
    repeat (4) file_bytes.push_back(8'h00);
    send_file(1'b1);

    // Empty image: header word closes the image, trailing bytes ignored.
    put_header(0, 8'd2, 0, 5, BPP_24);
    put_raw_pixels(1, 3);
    send_file(1'b1);

    // 16-bit 5-5-5 with a one-byte ID field, all-ones and all-zeros pixels.
    put_header(1, 8'd2, 2, 1, BPP_16);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    send_file(1'b1);

    // RLE at 16 bits is unsupported.
    put_header(0, TYPE_RLE, 2, 2, BPP_16);
    put_raw_pixels(1, 2);
    send_file(1'b1);

    // Odd depth byte.
    put_header(0, 8'd2, 1, 1, 8'd8);
    file_bytes.push_back(8'h55);
    send_file(1'b1);

    // Repeat packet of 128 on a 3-pixel image: run clipped to 3.
    put_header(0, TYPE_RLE, 3, 1, BPP_32);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h11);
    file_bytes.push_back(8'h22);
    file_bytes.push_back(8'h33);
    file_bytes.push_back(8'h44);
    file_bytes.push_back(8'h80);
    send_file(1'b1);

    // Full 128 run, then a raw packet of 5 where only 2 pixels remain.
    put_header(2, TYPE_RLE, 130, 1, BPP_24);
    file_bytes.push_back(8'hFF);
    put_raw_pixels(1, 3);
    file_bytes.push_back(8'h04);
    put_raw_pixels(5, 3);
    send_file(1'b1);

    // Restart in the middle of a packet.
    put_header(0, TYPE_RLE, 4, 1, BPP_24);
    file_bytes.push_back(8'h80);
    put_raw_pixels(1, 3);
    file_bytes.push_back(8'h02);
    put_raw_pixels(1, 3);
    send_file(1'b1);
    put_header(0, 8'd2, 1, 1, BPP_32);
    put_raw_pixels(1, 4);
    send_file(1'b1);

    wait_drained();

    // Random files; the receiver holds off for a long stretch at the start.
    parsed_count = 0;
    long_hold_req = 1'b1;
    while (parsed_count < RANDOM_BYTES) begin
      send_file(build_random_file());
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== tga_image_stream_decoder.f =====
design/tgasd_pkg.sv
design/tgasd_front.sv
design/tgasd_queue.sv
design/tgasd_back.sv
design/tga_image_stream_decoder.sv
bench/tb_tga_image_stream_decoder.sv
